// ----- src/bancl_pkg.sv -----
// ----------------------------------------------------------------------------
// bancl_pkg
// Shared types and constants of the advertisement name classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bancl_pkg;

    // classification codes on the result channel
    typedef enum logic [1:0] {
        FMT_NONE   = 2'd0,
        FMT_LEGACY = 2'd1,
        FMT_MODERN = 2'd2
    } bancl_fmt_t;

    // character flags of one name byte
    typedef struct packed {
        logic is_s;
        logic is_hex;
        logic is_role;
        logic is_vin;
    } bancl_class_t;

    localparam int unsigned POS_W = 5;

    localparam logic [POS_W-1:0] LEGACY_LEN      = 5'd18;
    localparam logic [POS_W-1:0] LEGACY_HEX      = 5'd16;
    localparam logic [POS_W-1:0] MODERN_HEAD_LEN = 5'd6;
    localparam logic [POS_W-1:0] SUFFIX_MIN      = 5'd4;
    localparam logic [POS_W-1:0] SUFFIX_MAX      = 5'd6;
    localparam logic [POS_W-1:0] POSITION_MAX    = 5'd19;

    localparam logic [7:0] CHAR_S = 8'h53;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_R = 8'h52;
    localparam logic [7:0] CHAR_D = 8'h44;
    localparam logic [7:0] CHAR_P = 8'h50;

    // six-byte prefix of the modern form
    localparam logic [7:0] MODERN_PREFIX [0:5] = '{8'h54, 8'h65, 8'h73, 8'h6C, 8'h61, 8'h20};

endpackage

`default_nettype wire

// ----- src/ble_adv_name_classifier_core.sv -----
// ----------------------------------------------------------------------------
// ble_adv_name_classifier_core
// Classifies an advertisement name streamed one byte per word.
//
// Input channel (s_): one name byte per word in s_tdata, s_tuser set when the
// word carries a byte, s_tlast on the final word of the name. A word with
// s_tuser low and s_tlast high is an empty name; with both low it is dropped.
// Result channel (m_): one word per name, sent for the word that carries
// s_tlast, holding the format code (0 none, 1 legacy, 2 modern).
// The result word passes through the input register, then the result register,
// before it shows on m_tvalid; a receiver stall can hold it between the two.
// Throughput: one input word per cycle while s_tready is high; the scan of each
// byte is a few compares and a 5-bit counter step between the two registers.
// When the receiver stalls, the result register holds its word and the
// input register still takes words that give no result; a final word waits
// in the input register and s_tready drops until the result slot frees.
// Reset (aresetn low, synchronous) empties both registers and restarts the
// scan at the first byte of a new name.
// ----------------------------------------------------------------------------
`default_nettype none

module ble_adv_name_classifier_core
    import bancl_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] name_byte
    input  wire logic         s_tuser,   // [0] byte_present
    input  wire logic         s_tlast,   // end_of_name
    // result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata    // [1:0] name_format, [7:2] zero
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_present_reg;
    logic         in_last_reg;

    logic         out_valid_reg;
    bancl_fmt_t   out_fmt_reg;

    logic         out_free;
    logic         advance;
    bancl_class_t char_class;
    bancl_fmt_t   fmt;

    // the held word moves on unless it needs the busy result slot
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg    <= s_tdata;
            in_present_reg <= s_tuser;
            in_last_reg    <= s_tlast;
        end
    end

    bancl_char_class u_class (
        .name_byte  (in_byte_reg),
        .char_class (char_class)
    );

    bancl_scan u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (advance),
        .name_byte    (in_byte_reg),
        .byte_present (in_present_reg),
        .end_of_name  (in_last_reg),
        .char_class   (char_class),
        .fmt          (fmt)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_fmt_reg <= fmt;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_fmt_reg};

endmodule

`default_nettype wire

// ----- src/bancl_char_class.sv -----
// ----------------------------------------------------------------------------
// bancl_char_class
// Sorts one name byte into the character groups the two name forms use.
// ----------------------------------------------------------------------------
`default_nettype none

module bancl_char_class
    import bancl_pkg::*;
(
    input  wire logic [7:0]   name_byte,
    output bancl_class_t      char_class
);

    logic is_digit;
    logic is_upper;
    logic is_lower_af;
    logic is_upper_af;

    // range compares
    assign is_digit    = (name_byte >= 8'h30) && (name_byte <= 8'h39);
    assign is_upper    = (name_byte >= 8'h41) && (name_byte <= 8'h5A);
    assign is_lower_af = (name_byte >= 8'h61) && (name_byte <= 8'h66);
    assign is_upper_af = (name_byte >= 8'h41) && (name_byte <= 8'h46);

    // group flags
    always_comb begin
        char_class.is_s    = (name_byte == CHAR_S);
        char_class.is_hex  = is_digit || is_lower_af || is_upper_af;
        char_class.is_role = (name_byte == CHAR_C) || (name_byte == CHAR_R) ||
                             (name_byte == CHAR_D) || (name_byte == CHAR_P);
        // vin alphabet leaves out I, O and Q
        char_class.is_vin  = is_digit ||
                             (is_upper && (name_byte != 8'h49) &&
                              (name_byte != 8'h4F) && (name_byte != 8'h51));
    end

endmodule

`default_nettype wire

// ----- src/bancl_scan.sv -----
// ----------------------------------------------------------------------------
// bancl_scan
// Per-name scan state: byte position and the two still-possible flags,
// plus the classification of the name on its final word.
// ----------------------------------------------------------------------------
`default_nettype none

module bancl_scan
    import bancl_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         fire,
    input  wire logic [7:0]   name_byte,
    input  wire logic         byte_present,
    input  wire logic         end_of_name,
    input  wire bancl_class_t char_class,
    output bancl_fmt_t        fmt
);

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic             leg_reg;
    logic             leg_next;
    logic             mod_reg;
    logic             mod_next;

    logic [POS_W-1:0] len;
    logic             leg_ok;
    logic             mod_ok;

    // per-position checks of the current byte
    always_comb begin
        if (pos_reg == '0) begin
            leg_ok = char_class.is_s;
        end else if (pos_reg <= LEGACY_HEX) begin
            leg_ok = char_class.is_hex;
        end else if (pos_reg == LEGACY_LEN - 5'd1) begin
            leg_ok = char_class.is_role;
        end else begin
            leg_ok = 1'b0;
        end

        if (pos_reg < MODERN_HEAD_LEN) begin
            mod_ok = (name_byte == MODERN_PREFIX[pos_reg[2:0]]);
        end else if (pos_reg < MODERN_HEAD_LEN + SUFFIX_MAX) begin
            mod_ok = char_class.is_vin;
        end else begin
            mod_ok = 1'b0;
        end

        len = (pos_reg < POSITION_MAX) ? pos_reg + 5'd1 : pos_reg;
    end

    // classification on the final word
    always_comb begin
        fmt = FMT_NONE;
        if (byte_present) begin
            if (leg_reg && leg_ok && (len == LEGACY_LEN)) begin
                fmt = FMT_LEGACY;
            end else if (mod_reg && mod_ok && (len >= MODERN_HEAD_LEN + SUFFIX_MIN) &&
                         (len <= MODERN_HEAD_LEN + SUFFIX_MAX)) begin
                fmt = FMT_MODERN;
            end
        end
    end

    // state update
    always_comb begin
        pos_next = pos_reg;
        leg_next = leg_reg;
        mod_next = mod_reg;
        if (fire) begin
            if (end_of_name) begin
                pos_next = '0;
                leg_next = 1'b1;
                mod_next = 1'b1;
            end else if (byte_present) begin
                pos_next = len;
                leg_next = leg_reg && leg_ok;
                mod_next = mod_reg && mod_ok;
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            leg_reg <= 1'b1;
            mod_reg <= 1'b1;
        end else begin
            pos_reg <= pos_next;
            leg_reg <= leg_next;
            mod_reg <= mod_next;
        end
    end

endmodule

`default_nettype wire

// ----- test/ble_adv_name_classifier_core_tb.sv -----
// ----------------------------------------------------------------------------
// ble_adv_name_classifier_core_tb
// Streams advertisement names into the classifier one byte per word and checks
// every format code on the result channel against a scan model kept in the
// bench. A directed set of boundary names runs first, then random names of
// both forms, damaged copies, long names, empty and aborted names, under
// several sender and receiver pacing modes.
// ----------------------------------------------------------------------------

module ble_adv_name_classifier_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bancl_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 12;
    localparam int PHASE_WORDS  = 320;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum int {
        PACE_FULL,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } pace_t;

    typedef struct packed {
        logic [7:0] name_byte;
        logic       byte_present;
        logic       end_of_name;
    } name_word_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;   // [7:0] name_byte
    logic       s_tuser  = 1'b0; // [0] byte_present
    logic       s_tlast  = 1'b0; // end_of_name
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;         // [1:0] name_format, [7:2] zero

    name_word_t pending_words[$];
    bancl_fmt_t expected_fmt[$];
    logic [7:0] name_buf[$];

    pace_t pace         = PACE_FULL;
    int    filler_pct   = 0;
    int    words_queued = 0;
    int    names_queued = 0;
    int    fail_count   = 0;
    int    cycle_count  = 0;
    int    fmt_seen[3]  = '{0, 0, 0};
    logic  word_taken   = 1'b0;

    // scan state of the bench model
    logic [POS_W-1:0] scan_pos  = '0;
    logic             legacy_ok = 1'b1;
    logic             modern_ok = 1'b1;

    ble_adv_name_classifier_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // character classes
    function automatic logic is_hex_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic is_vin_char(logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return 1'b1;
        end
        return c >= "A" && c <= "Z" && c != "I" && c != "O" && c != "Q";
    endfunction

    function automatic logic is_role_char(logic [7:0] c);
        return c == CHAR_C || c == CHAR_R || c == CHAR_D || c == CHAR_P;
    endfunction

    function automatic int send_idle_pct(pace_t p);
        case (p)
            PACE_SEND_IDLE: return 70;
            PACE_BOTH:      return 17;
            default:        return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct(pace_t p);
        case (p)
            PACE_RECV_STALL: return 70;
            PACE_BOTH:       return 17;
            default:         return 0;
        endcase
    endfunction

    // advance the scan by one accepted word, queue a format code on end of name
    task automatic scan_word(input name_word_t w);
        logic [POS_W-1:0] len;
        bancl_fmt_t       fmt;
        if (w.byte_present) begin
            // legacy form: S, sixteen hex digits, role letter, nothing after
            if (scan_pos == 0) begin
                if (w.name_byte != CHAR_S) legacy_ok = 1'b0;
            end else if (scan_pos <= LEGACY_HEX) begin
                if (!is_hex_char(w.name_byte)) legacy_ok = 1'b0;
            end else if (scan_pos == LEGACY_LEN - 1) begin
                if (!is_role_char(w.name_byte)) legacy_ok = 1'b0;
            end else begin
                legacy_ok = 1'b0;
            end
            // modern form: fixed prefix, then up to six vin characters
            if (scan_pos < MODERN_HEAD_LEN) begin
                if (w.name_byte != MODERN_PREFIX[scan_pos]) modern_ok = 1'b0;
            end else if (scan_pos < MODERN_HEAD_LEN + SUFFIX_MAX) begin
                if (!is_vin_char(w.name_byte)) modern_ok = 1'b0;
            end else begin
                modern_ok = 1'b0;
            end
            if (scan_pos < POSITION_MAX) scan_pos = scan_pos + 1'b1;
        end
        if (w.end_of_name) begin
            len = scan_pos;
            fmt = FMT_NONE;
            if (w.byte_present && legacy_ok && len == LEGACY_LEN) begin
                fmt = FMT_LEGACY;
            end else if (w.byte_present && modern_ok && len >= MODERN_HEAD_LEN + SUFFIX_MIN &&
                         len <= MODERN_HEAD_LEN + SUFFIX_MAX) begin
                fmt = FMT_MODERN;
            end
            expected_fmt.push_back(fmt);
            scan_pos  = '0;
            legacy_ok = 1'b1;
            modern_ok = 1'b1;
        end
    endtask

    // input driver: new word at the falling edge once the previous one is taken
    always @(negedge aclk) begin : word_driver
        name_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct(pace)) begin
                w = pending_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= w.name_byte;
                s_tuser  <= w.byte_present;
                s_tlast  <= w.end_of_name;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct(pace));
    end

    // monitor: predict on accepted input words, check accepted result words
    always @(posedge aclk) begin : result_check
        bancl_fmt_t want;
        word_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                scan_word({s_tdata, s_tuser, s_tlast});
            end
            if (m_tvalid && m_tready) begin
                if (expected_fmt.size() == 0) begin
                    $display("%0t: result word %h with no name pending", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_fmt.pop_front();
                    fmt_seen[want]++;
                    if (m_tdata !== {6'd0, want}) begin
                        $display("%0t: name_format mismatch, expected %h got %h",
                                 $time, {6'd0, want}, m_tdata);
                        fail_count++;
                    end
                end
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_fmt.size());
            $display("** ble_adv_name_classifier_core: FAILED **");
            $finish;
        end
    end

    // name building helpers
    function automatic logic [7:0] pick(string set);
        return set[$urandom_range(set.len() - 1)];
    endfunction

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++) name_buf.push_back(s[i]);
    endtask

    task automatic put_prefix();
        for (int i = 0; i < MODERN_HEAD_LEN; i++) name_buf.push_back(MODERN_PREFIX[i]);
    endtask

    task automatic put_hex(input int n);
        repeat (n) name_buf.push_back(pick("0123456789abcdefABCDEF"));
    endtask

    task automatic put_vin(input int n);
        repeat (n) name_buf.push_back(pick("0123456789ABCDEFGHJKLMNPRSTUVWXYZ"));
    endtask

    task automatic put_noise(input int n);
        repeat (n) name_buf.push_back($urandom_range(255));
    endtask

    task automatic put_legacy();
        name_buf.push_back(CHAR_S);
        put_hex(LEGACY_HEX);
        name_buf.push_back(pick("CRDP"));
    endtask

    task automatic damage_one();
        if (name_buf.size() != 0) name_buf[$urandom_range(name_buf.size() - 1)] = $urandom_range(255);
    endtask

    // move the built name into the word queue; an empty name becomes the marker
    task automatic queue_name(input bit aborted);
        name_word_t w;
        for (int i = 0; i < name_buf.size(); i++) begin
            if ($urandom_range(99) < filler_pct) begin
                w.name_byte    = $urandom_range(255);
                w.byte_present = 1'b0;
                w.end_of_name  = 1'b0;
                pending_words.push_back(w);
            end
            w.name_byte    = name_buf[i];
            w.byte_present = 1'b1;
            w.end_of_name  = !aborted && (i == name_buf.size() - 1);
            pending_words.push_back(w);
            words_queued++;
        end
        if (aborted || name_buf.size() == 0) begin
            w.name_byte    = $urandom_range(255);
            w.byte_present = 1'b0;
            w.end_of_name  = 1'b1;
            pending_words.push_back(w);
            words_queued++;
        end
        names_queued++;
        name_buf.delete();
    endtask

    task automatic random_name();
        int kind;
        bit aborted;
        kind    = $urandom_range(99);
        aborted = 1'b0;
        if (kind < 30) begin
            put_legacy();
            if ($urandom_range(3) == 0) damage_one();
        end else if (kind < 60) begin
            put_prefix();
            put_vin($urandom_range(SUFFIX_MIN, SUFFIX_MAX));
            if ($urandom_range(3) == 0) damage_one();
        end else if (kind < 70) begin
            put_prefix();
            put_vin($urandom_range(0, 9));
        end else if (kind < 78) begin
            name_buf.push_back(CHAR_S);
            put_hex($urandom_range(13, 19));
            name_buf.push_back(pick("CRDPA"));
        end else if (kind < 88) begin
            put_noise($urandom_range(1, 30));
        end else if (kind < 92) begin
            // at and past the counter saturation
            put_legacy();
            put_hex($urandom_range(1, 20));
        end else if (kind < 96) begin
            // empty name marker
        end else begin
            if ($urandom_range(1)) put_legacy();
            else put_noise($urandom_range(1, 12));
            aborted = 1'b1;
        end
        queue_name(aborted);
    endtask

    // wait until every word is sent and every result has come back
    task automatic drain_results();
        while (pending_words.size() != 0 || s_tvalid || expected_fmt.size() != 0)
            @(negedge aclk);
    endtask

    initial begin : stimulus
        int phase_start;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: legacy form, every role letter, both hex cases
        put_str("S0123456789abcdefC"); queue_name(0);
        put_str("SABCDEF9876543210R"); queue_name(0);
        put_str("Sfedcba0123456789D"); queue_name(0);
        put_str("SFFFFFFFF"); put_str("FFFFFFFFP"); queue_name(0);
        // legacy rejects: hex field boundaries, bad role, lowercase s, lengths
        put_str("S/:@G`g0123456789C"); queue_name(0);
        put_str("S0123456789abcdefA"); queue_name(0);
        put_str("s0123456789abcdefC"); queue_name(0);
        put_str("S0123456789abcdeC");  queue_name(0);
        put_str("S0123456789abcdefCC"); queue_name(0);
        // modern form at four, five and six characters
        put_prefix(); put_str("0A9Z");   queue_name(0);
        put_prefix(); put_str("HJKLM");  queue_name(0);
        put_prefix(); put_str("PRSTUV"); queue_name(0);
        // modern rejects: excluded letters, short and long suffix, boundaries
        put_prefix(); put_str("ABI9");    queue_name(0);
        put_prefix(); put_str("OQ12");    queue_name(0);
        put_prefix(); put_str("ABC");     queue_name(0);
        put_prefix(); put_str("ABCDEFG"); queue_name(0);
        put_prefix(); put_str("@[a/");    queue_name(0);
        put_prefix(); queue_name(0);
        // empty name, ignored markers between bytes, aborted name
        queue_name(0);
        filler_pct = 100;
        put_prefix(); put_str("WXY8"); queue_name(0);
        filler_pct = 0;
        put_str("S0123456789"); queue_name(1);
        // saturating length, extreme byte values, single byte
        put_str("S0123456789abcdef0123456789abcdef"); queue_name(0);
        name_buf.push_back(8'h00); name_buf.push_back(8'hFF); queue_name(0);
        put_str("S"); queue_name(0);
        drain_results();

        // random names under each pacing mode, fully drained between modes
        filler_pct = 5;
        for (int p = 0; p < 4; p++) begin
            pace = pace_t'(p);
            phase_start = words_queued;
            while (words_queued - phase_start < PHASE_WORDS) random_name();
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("ran %0d names in %0d words: %0d none, %0d legacy, %0d modern",
                 names_queued, words_queued, fmt_seen[FMT_NONE], fmt_seen[FMT_LEGACY],
                 fmt_seen[FMT_MODERN]);
        $display("pacing: free flow, sender gaps, receiver stalls, both; %0d mismatches",
                 fail_count);
        if (fail_count == 0) begin
            $display("** ble_adv_name_classifier_core: PASSED **");
        end else begin
            $display("** ble_adv_name_classifier_core: FAILED **");
        end
        $finish;
    end

endmodule
